// File: rtl/dqs_pkg.sv
// Shared types, widths and codes for the double-ended queue with search.
package dqs_pkg;

    // Number of entries in the ring store.
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths of the input and result words.
    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int POSITION_W = 7;
    localparam int COUNT_W    = 7;

    localparam int IN_FIELDS_W  = OPCODE_W + VALUE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + POSITION_W + VALUE_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic pop_done;
        logic search_step;
        logic out_load;
    } dqs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_wait;
        logic search_wait;
        logic search_done;
        logic out_free;
    } dqs_sts_t;

endpackage

// File: rtl/deque_with_search.sv
// Top level of the double-ended queue with linear search.
//
// This block holds up to DEPTH (64) signed 32-bit entries in a ring store with a front
// pointer and an entry count, and takes one operation word at a time: push front, push
// back, pop front, pop back or search. Every input word gives exactly one result word with
// a status, the 1-based search position, the value removed by a pop and the entry count
// after the operation. A push to a full store or a pop from an empty one reports its status
// and leaves the contents unchanged; unused opcodes report ok and change nothing. Each
// accepted word passes an execute step; a pop then takes a read step, and a search compares
// the entries from the front, one per cycle and up to the entry count, since the single read
// port of the store delivers one entry each cycle, and stops at the first hit. Pushes,
// unused opcodes and failed operations go straight on to the result. The result is loaded
// into the output register once that register is free, and the next word can be accepted
// in the cycle after the result is loaded. A new word is taken once the previous one is
// finished, while its result may still be waiting in the output register for the downstream
// side. No clearing pass follows reset: entries are read only after they were written.
module deque_with_search
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [2:0] opcode, [34:3] value, [39:35] zero
    input  logic [dqs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [8:2] position, [40:9] removed_value, [47:41] entry_count
    output logic [dqs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import dqs_pkg::*;

    dqs_cmd_t cmd;
    dqs_sts_t sts;

    // The controller sequences each operation through execute, read and search steps.
    dqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns the store, the pointers and the output register.
    dqs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // One word is in work at a time: acceptance closes the input for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while a word is in work");

    // A search position is only reported together with a found status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[8:2] != 7'd0)) |-> (m_axis_tdata[1:0] == ST_OK))
        else $error("search position reported without found status");

    // A full or empty status never carries a removed value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tdata[1:0] == ST_FULL) || (m_axis_tdata[1:0] == ST_EMPTY)))
        |-> (m_axis_tdata[40:9] == 32'd0))
        else $error("removed value reported on a failed operation");

endmodule

// File: rtl/dqs_ctrl.sv
// Controller state machine that sequences one operation at a time.
module dqs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dqs_pkg::dqs_sts_t sts,
    output dqs_pkg::dqs_cmd_t cmd
);
    import dqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_POP    = 5'b00100,
        S_SEARCH = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (sts.pop_wait)
                    state_next = S_POP;
                else if (sts.search_wait)
                    state_next = S_SEARCH;
                else
                    state_next = S_RESULT;
            end
            S_POP:
            begin
                cmd.pop_done = 1'b1;
                state_next   = S_RESULT;
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.search_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/dqs_dp.sv
// Datapath: ring store, pointers, search walk and the result output register.
module dqs_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dqs_pkg::dqs_cmd_t                cmd,
    output dqs_pkg::dqs_sts_t                sts,
    input  logic [dqs_pkg::IN_DATA_W-1:0]   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dqs_pkg::OUT_DATA_W-1:0]  out_data
);
    import dqs_pkg::*;

    localparam int SUM_W = PTR_W + 2;

    // Ring index of the entry that lies off entries behind the front.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
            sum = sum - SUM_W'(DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    status_t             res_status_reg, res_status_next;
    logic [CNT_W-1:0]    res_pos_reg, res_pos_next;
    logic [VALUE_W-1:0]  res_removed_reg, res_removed_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic               is_full, is_empty, search_hit, search_last;
    logic [CNT_W-1:0]   count_dec, rd_off;
    logic [PTR_W-1:0]   front_dec, front_inc, rd_addr, wr_addr;
    logic               mem_we, mem_re;
    logic [31:0]        count_wide, pos_wide;

    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign count_dec   = count_reg - CNT_W'(1);
    assign front_dec   = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc   = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);
    assign search_hit  = (rd_data_reg == val_reg);
    assign search_last = (pos_reg == count_reg);

    always_comb
    begin
        priority if (op_reg == OP_POP_BACK)
            rd_off = count_dec;
        else if (op_reg == OP_SEARCH)
            rd_off = idx_reg;
        else
            rd_off = '0;
    end

    assign rd_addr = ring_add(front_reg, rd_off);
    assign wr_addr = (op_reg == OP_PUSH_FRONT) ? front_dec : ring_add(front_reg, count_reg);

    assign count_wide = 32'(count_reg);
    assign pos_wide   = 32'(res_pos_reg);

    always_comb
    begin
        op_next          = op_reg;
        val_next         = val_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        res_status_next  = res_status_reg;
        res_pos_next     = res_pos_reg;
        res_removed_next = res_removed_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        priority if (cmd.load)
        begin
            op_next          = in_data[OPCODE_W-1:0];
            val_next         = in_data[IN_FIELDS_W-1:OPCODE_W];
            idx_next         = '0;
            pos_next         = '0;
            res_status_next  = ST_OK;
            res_pos_next     = '0;
            res_removed_next = '0;
        end
        else if (cmd.exec)
        begin
            unique case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                        res_status_next = ST_FULL;
                    else
                    begin
                        mem_we     = 1'b1;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (is_full)
                        res_status_next = ST_FULL;
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (is_empty)
                        res_status_next = ST_EMPTY;
                    else
                        mem_re = 1'b1;
                end
                OP_SEARCH:
                begin
                    if (is_empty)
                        res_status_next = ST_NOT_FOUND;
                    else
                    begin
                        // Read the front entry; it is compared in the first search step.
                        mem_re   = 1'b1;
                        idx_next = CNT_W'(1);
                        pos_next = CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.pop_done)
        begin
            res_removed_next = rd_data_reg;
            count_next       = count_dec;
            if (op_reg == OP_POP_FRONT)
                front_next = front_inc;
        end
        else if (cmd.search_step)
        begin
            priority if (search_hit)
            begin
                res_status_next = ST_OK;
                res_pos_next    = pos_reg;
            end
            else if (search_last)
                res_status_next = ST_NOT_FOUND;
            else
            begin
                mem_re   = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                pos_next = pos_reg + CNT_W'(1);
            end
        end
        else
        begin
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_DATA_W'({count_wide[COUNT_W-1:0], res_removed_reg,
                                          pos_wide[POSITION_W-1:0], res_status_reg});
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= val_reg;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        res_status_reg  <= res_status_next;
        res_pos_reg     <= res_pos_next;
        res_removed_reg <= res_removed_next;
        out_data_reg    <= out_data_next;
    end

    assign sts.pop_wait    = ((op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK)) && !is_empty;
    assign sts.search_wait = (op_reg == OP_SEARCH) && !is_empty;
    assign sts.search_done = search_hit || search_last;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: dv/deque_with_search_tb.sv
// Self-checking testbench for the double-ended queue with search.
`timescale 1ns / 100ps

module deque_with_search_tb;

    import dqs_pkg::*;

    // Opcodes 5 to 7 are unused; the block must report ok and change nothing.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam logic [VALUE_W-1:0] VAL_MIN_NEG = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MINUS_1 = 32'hFFFF_FFFF;

    // Cycles with no word moving on either side before the run is given up.
    localparam int STALL_LIMIT  = 4000;
    // Longest operation is a search over a full store.
    localparam int DRAIN_CYCLES = 2 * (DEPTH + 8);
    // Random words per block of one operation mix (filling, draining, balanced).
    localparam int MIX_BLOCK    = 120;

    // Result word as it sits on m_axis_tdata, status in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0]    entry_count;
        logic [VALUE_W-1:0]    removed_value;
        logic [POSITION_W-1:0] position;
        status_t               status;
    } dqs_result_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  val;
        bit                  typed;
        dqs_result_t         res;
    } op_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    deque_with_search uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the deque contents.
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    int                 shadow_front = 0;
    int                 shadow_count = 0;

    dqs_result_t pending_results[$];
    op_row_t     directed_rows[$];

    // Set by the sender before a word goes out: a typed row carries its own result.
    bit          row_typed = 1'b0;
    dqs_result_t row_result = '0;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int error_count       = 0;
    int stall_cycles      = 0;
    int mix_index         = 0;

    logic        in_taken;
    logic        out_taken;
    dqs_result_t predicted;
    dqs_result_t observed;
    dqs_result_t wanted;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one operation to the shadow deque and returns the result it gives.
    function automatic dqs_result_t deque_apply(input logic [OPCODE_W-1:0] op,
                                                input logic [VALUE_W-1:0]  val);
        dqs_result_t r;
        bit          hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        case (op)
            OP_PUSH_FRONT:
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_store[shadow_front] = val;
                    shadow_count++;
                end
            OP_PUSH_BACK:
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
                    shadow_count++;
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.removed_value = shadow_store[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            OP_POP_BACK:
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.removed_value = shadow_store[(shadow_front + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            OP_SEARCH:
            begin
                // The first equal entry from the front wins.
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_store[(shadow_front + i) % DEPTH] == val)
                    begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.position = POSITION_W'(i + 1);
                    end
                end
            end
            default:
                ;
        endcase
        r.entry_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic void add_row(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                                    input bit typed, input status_t st, input int pos,
                                    input logic [VALUE_W-1:0] removed, input int cnt);
        op_row_t row;
        row.op = op;
        row.val = val;
        row.typed = typed;
        row.res.status = st;
        row.res.position = POSITION_W'(pos);
        row.res.removed_value = removed;
        row.res.entry_count = COUNT_W'(cnt);
        directed_rows.push_back(row);
    endfunction

    // Values drawn from a small pool repeat often, so searches see duplicates.
    function automatic logic [VALUE_W-1:0] pick_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        if (pick < 7)
            return VALUE_W'(int'($urandom_range(7)) - 4);
        case ($urandom_range(3))
            0:       return VAL_MIN_NEG;
            1:       return VAL_MAX_POS;
            2:       return '0;
            default: return VAL_MINUS_1;
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance.
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input bit typed, input dqs_result_t res);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        row_typed = typed;
        row_result = res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, val, op};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Blocks of words alternate between a filling mix, a draining mix and a balanced one,
    // so the store runs into both its full and its empty ends and wraps around often.
    task automatic send_random(input int n_words);
        int                  push_pct;
        int                  pop_pct;
        int                  roll;
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  val;
        for (int k = 0; k < n_words; k++)
        begin
            case ((mix_index / MIX_BLOCK) % 3)
                0:       begin push_pct = 70; pop_pct = 10; end
                1:       begin push_pct = 10; pop_pct = 70; end
                default: begin push_pct = 40; pop_pct = 40; end
            endcase
            mix_index++;
            roll = $urandom_range(99);
            val = pick_value();
            if (roll < push_pct / 2)
                op = OP_PUSH_FRONT;
            else if (roll < push_pct)
                op = OP_PUSH_BACK;
            else if (roll < push_pct + pop_pct / 2)
                op = OP_POP_FRONT;
            else if (roll < push_pct + pop_pct)
                op = OP_POP_BACK;
            else if (roll < 97)
            begin
                op = OP_SEARCH;
                // Mostly search for something that is held, at any depth.
                if (shadow_count > 0 && $urandom_range(99) < 65)
                    val = shadow_store[(shadow_front + $urandom_range(shadow_count - 1)) % DEPTH];
            end
            else
                op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            send_word(op, val, 1'b0, '0);
        end
    endtask

    // Receiver side: a new ready decision every falling edge.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Predicts on every accepted input word, checks every accepted result word, and
    // watches for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = s_axis_tvalid && s_axis_tready;
            out_taken = m_axis_tvalid && m_axis_tready;
            if (in_taken)
            begin
                predicted = deque_apply(s_axis_tdata[OPCODE_W-1:0],
                                        s_axis_tdata[OPCODE_W +: VALUE_W]);
                pending_results.push_back(row_typed ? row_result : predicted);
            end
            if (out_taken)
            begin
                observed = dqs_result_t'(m_axis_tdata);
                if (pending_results.size() == 0)
                begin
                    $error("result word with no expectation waiting: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (observed.status !== wanted.status)
                    begin
                        $error("status: expected %0d, got %0d", wanted.status, observed.status);
                        error_count++;
                    end
                    if (observed.position !== wanted.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               wanted.position, observed.position);
                        error_count++;
                    end
                    if (observed.removed_value !== wanted.removed_value)
                    begin
                        $error("removed_value: expected %h, got %h",
                               wanted.removed_value, observed.removed_value);
                        error_count++;
                    end
                    if (observed.entry_count !== wanted.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               wanted.entry_count, observed.entry_count);
                        error_count++;
                    end
                end
            end
            if (in_taken || out_taken)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed words: empty-store cases, extremes, wrap of the front pointer
        // below zero, duplicates for search, unused opcodes, then draining to empty.
        add_row(OP_POP_FRONT,  VAL_MAX_POS,   1, ST_EMPTY,     0, '0,          0);
        add_row(OP_POP_BACK,   VAL_MIN_NEG,   1, ST_EMPTY,     0, '0,          0);
        add_row(OP_SEARCH,     '0,            1, ST_NOT_FOUND, 0, '0,          0);
        add_row(OP_UNUSED_LO,  VAL_MINUS_1,   1, ST_OK,        0, '0,          0);
        add_row(OP_PUSH_BACK,  VAL_MAX_POS,   1, ST_OK,        0, '0,          1);
        add_row(OP_PUSH_FRONT, VAL_MIN_NEG,   1, ST_OK,        0, '0,          2);
        add_row(OP_PUSH_BACK,  VAL_MINUS_1,   1, ST_OK,        0, '0,          3);
        add_row(OP_PUSH_FRONT, '0,            1, ST_OK,        0, '0,          4);
        add_row(OP_PUSH_BACK,  VAL_MIN_NEG,   1, ST_OK,        0, '0,          5);
        add_row(OP_SEARCH,     VAL_MIN_NEG,   1, ST_OK,        2, '0,          5);
        add_row(OP_SEARCH,     VAL_MINUS_1,   1, ST_OK,        4, '0,          5);
        add_row(OP_SEARCH,     '0,            1, ST_OK,        1, '0,          5);
        add_row(OP_SEARCH,     32'h1234_5678, 1, ST_NOT_FOUND, 0, '0,          5);
        add_row(OP_UNUSED_LO + 3'd1, '0,      1, ST_OK,        0, '0,          5);
        add_row(OP_UNUSED_HI,  VAL_MAX_POS,   1, ST_OK,        0, '0,          5);
        add_row(OP_POP_BACK,   '0,            1, ST_OK,        0, VAL_MIN_NEG, 4);
        add_row(OP_POP_FRONT,  '0,            1, ST_OK,        0, '0,          3);
        add_row(OP_POP_FRONT,  VAL_MINUS_1,   0, ST_OK,        0, '0,          0);
        add_row(OP_SEARCH,     VAL_MAX_POS,   0, ST_OK,        0, '0,          0);
        add_row(OP_POP_BACK,   '0,            1, ST_OK,        0, VAL_MINUS_1, 1);
        add_row(OP_POP_BACK,   '0,            1, ST_OK,        0, VAL_MAX_POS, 0);
        add_row(OP_POP_FRONT,  '0,            1, ST_EMPTY,     0, '0,          0);
        add_row(OP_SEARCH,     VAL_MAX_POS,   1, ST_NOT_FOUND, 0, '0,          0);

        sender_idle_pct = 9;
        receiver_idle_pct = 65;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].res);

        // Sender mostly busy, receiver mostly stalling.
        wait_for_results();
        send_random(600);

        // Sender mostly idle, receiver mostly ready.
        sender_idle_pct = 65;
        receiver_idle_pct = 9;
        wait_for_results();
        send_random(600);

        // Full rate on both sides.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        wait_for_results();
        send_random(550);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Catch any stray result word after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: deque_with_search.f
rtl/dqs_pkg.sv
rtl/dqs_ctrl.sv
rtl/dqs_dp.sv
rtl/deque_with_search.sv
dv/deque_with_search_tb.sv
